// File: hw/rtl/block_bitmap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Field widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 7;
  localparam int BLOCK_W    = 6;
  localparam int NEED_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_CONTIG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_BLOCK,
    RES_FREE
  } res_kind_e;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      seek;
    logic      out_load;
    res_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic cur_free;
    logic bad_op;
    logic is_free;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bba_datapath.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Free bitmap, scan index, run/fill counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bba_pkg::cmd_t               cmd_i,
  output bba_pkg::sts_t                    sts_o,
  input  wire logic [bba_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [bba_pkg::COUNT_W-1:0] count_i,
  input  wire logic [bba_pkg::BLOCK_W-1:0] block_i,
  output logic                             ok_o,
  output logic [bba_pkg::BLOCK_W-1:0]      block_res_o,
  output logic                             last_o
);
  import bba_pkg::*;

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [NUM_BLOCKS-1:0] free_q, free_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         start_q, start_d;
  logic [NEED_W-1:0]     cnt_q, cnt_d;
  logic [NEED_W-1:0]     need_q, need_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [BLOCK_W-1:0]    block_q, block_d;
  logic                  ok_q, ok_d;
  logic [BLOCK_W-1:0]    res_q, res_d;
  logic                  last_q, last_d;

  logic              cur_free;
  logic              is_contig;
  logic              at_need;
  logic              in_range;
  logic [NEED_W-1:0] cnt_inc;

  assign cur_free  = free_q[idx_q];
  assign is_contig = (mode_q == MODE_CONTIG);
  assign cnt_inc   = cnt_q + NEED_W'(1);
  assign at_need   = (cnt_inc == need_q);
  assign in_range  = ({1'b0, block_q} < (BLOCK_W + 1)'(NUM_BLOCKS));

  assign sts_o.hit      = cur_free && at_need;
  assign sts_o.scan_end = (idx_q == IW'(NUM_BLOCKS - 1));
  assign sts_o.cur_free = cur_free;
  assign sts_o.bad_op   = (mode_q == MODE_NONE) ||
                          (is_contig && ((count_q == '0) ||
                                         (count_q > COUNT_W'(NUM_BLOCKS))));
  assign sts_o.is_free  = (mode_q == MODE_FREE);
  assign sts_o.last     = last_q;

  always_comb begin
    free_d  = free_q;
    idx_d   = idx_q;
    start_d = start_q;
    cnt_d   = cnt_q;
    need_d  = need_q;
    mode_d  = mode_q;
    count_d = count_q;
    block_d = block_q;
    ok_d    = ok_q;
    res_d   = res_q;
    last_d  = last_q;

    if (cmd_i.load) begin
      mode_d  = mode_i;
      count_d = count_i;
      block_d = block_i;
      need_d  = (mode_i == MODE_INDEXED) ? ({1'b0, count_i} + NEED_W'(1)) : {1'b0, count_i};
      idx_d   = '0;
      cnt_d   = '0;
    end

    if (cmd_i.scan) begin
      if (cur_free && at_need) begin
        idx_d = is_contig ? ((cnt_q == '0) ? idx_q : start_q) : '0;
        cnt_d = '0;
      end else begin
        idx_d = idx_q + IW'(1);
        if (cur_free) begin
          cnt_d = cnt_inc;
          if (cnt_q == '0) begin
            start_d = idx_q;
          end
        end else if (is_contig) begin
          cnt_d = '0;
        end
      end
    end

    if (cmd_i.seek) begin
      idx_d = idx_q + IW'(1);
    end

    if (cmd_i.out_load) begin
      case (cmd_i.kind)
        RES_BLOCK: begin
          ok_d          = 1'b1;
          res_d         = BLOCK_W'(idx_q);
          last_d        = at_need;
          free_d[idx_q] = 1'b0;
          idx_d         = idx_q + IW'(1);
          cnt_d         = cnt_inc;
        end
        RES_FREE: begin
          ok_d   = in_range;
          res_d  = block_q;
          last_d = 1'b1;
          if (in_range) begin
            free_d[block_q[IW-1:0]] = 1'b1;
          end
        end
        default: begin
          ok_d   = 1'b0;
          res_d  = '0;
          last_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    start_q <= start_d;
    cnt_q   <= cnt_d;
    need_q  <= need_d;
    mode_q  <= mode_d;
    count_q <= count_d;
    block_q <= block_d;
    ok_q    <= ok_d;
    res_q   <= res_d;
    last_q  <= last_d;
  end

  assign ok_o        = ok_q;
  assign block_res_o = res_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/bba_controller.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences load, bitmap scan, block emission and result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bba_pkg::cmd_t      cmd_o,
  input  wire bba_pkg::sts_t sts_i
);
  import bba_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FAIL = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.load     = 1'b0;
    cmd_o.scan     = 1'b0;
    cmd_o.seek     = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.kind     = RES_FAIL;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts_i.is_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = RES_FREE;
          state_d        = ST_OUT;
        end else if (sts_i.bad_op) begin
          state_d = ST_FAIL;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_EMIT;
        end else if (sts_i.scan_end) begin
          state_d = ST_FAIL;
        end
      end
      ST_FAIL: begin
        cmd_o.out_load = 1'b1;
        cmd_o.kind     = RES_FAIL;
        state_d        = ST_OUT;
      end
      ST_EMIT: begin
        if (sts_i.cur_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = RES_BLOCK;
          state_d        = ST_OUT;
        end else begin
          cmd_o.seek = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = sts_i.last ? ST_IDLE : ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit contiguous and indexed block allocation over a free bitmap.
// ----------------------------------------------------------------------------
// One request enters on the slave stream: tuser carries the operation
// (contiguous allocate, indexed allocate, free), tdata the count and block.
// The master stream returns the results: one transaction per allocated block
// number in ascending order with tlast on the final one, or a single
// transaction for a free or a failed request.
// A request is taken only when the block is idle; tready drops on accept
// and rises again in the cycle after the last result transaction completes.
// Each request is dispatched, then the bitmap is scanned one entry per
// cycle, then each result is emitted, with used entries skipped one at a
// time for an indexed allocation. A free request and an invalid one skip
// the scan and return a single result. The bitmap has a single read port,
// shared by the scan and the emission.
// Reset marks every block free and returns to idle. When the receiver
// stalls, the result register holds and the scan pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // count[6:0], block[12:7], zero[15:13]
  input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // ok[0], block_res[6:1], zero[7]
  output logic             m_axis_tlast
);
  import bba_pkg::*;

  `include "block_bitmap_allocator_defines.svh"

  cmd_t               cmd;
  sts_t               sts;
  logic               res_ok;
  logic [BLOCK_W-1:0] res_block;

  bba_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (s_axis_tuser),
    .count_i     (s_axis_tdata[COUNT_W-1:0]),
    .block_i     (s_axis_tdata[COUNT_W+BLOCK_W-1:COUNT_W]),
    .ok_o        (res_ok),
    .block_res_o (res_block),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, res_block, res_ok};

  `BBA_ASSERT(a_one_side, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
  `BBA_ASSERT_IMPL(a_fail_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tlast, "failure result without last")
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted twice")
  `BBA_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid, "not idle after last result")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives allocate, free and invalid requests, first from a fixed table and
// then at random, with idle cycles on both streams. A free-map shadow or a
// table row predicts every result transaction, compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bba_pkg::*;

  localparam int NUM_BLOCKS   = 64;
  localparam int RANDOM_ITEMS = 380;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic               ok;
    logic [BLOCK_W-1:0] blk;
    logic               last;
  } grant_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [BLOCK_W-1:0] blk;
    logic               known;
    logic               k_ok;
    logic [BLOCK_W-1:0] k_blk;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  grant_t                pending_grants[$];
  logic [NUM_BLOCKS-1:0] free_blocks;
  int                    mismatches = 0;
  logic                  calm_tx;
  logic                  calm_rx;

  dir_row_t dir_rows [21] = '{
    '{MODE_NONE,    7'h7f, 6'h3f, 1'b1, 1'b0, 6'd0},
    '{MODE_CONTIG,  7'd0,  6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_CONTIG,  7'd65, 6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_CONTIG,  7'h7f, 6'h3f, 1'b1, 1'b0, 6'd0},
    '{MODE_INDEXED, 7'd64, 6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_INDEXED, 7'h7f, 6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_INDEXED, 7'd63, 6'd0,  1'b0, 1'b0, 6'd0},
    '{MODE_CONTIG,  7'd1,  6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_INDEXED, 7'd0,  6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_FREE,    7'd0,  6'd0,  1'b1, 1'b1, 6'd0},
    '{MODE_FREE,    7'h7f, 6'd63, 1'b1, 1'b1, 6'd63},
    '{MODE_FREE,    7'd5,  6'd42, 1'b1, 1'b1, 6'd42},
    '{MODE_FREE,    7'd0,  6'd63, 1'b1, 1'b1, 6'd63},
    '{MODE_CONTIG,  7'd2,  6'd0,  1'b1, 1'b0, 6'd0},
    '{MODE_INDEXED, 7'd2,  6'd0,  1'b0, 1'b0, 6'd0},
    '{MODE_FREE,    7'd0,  6'd10, 1'b1, 1'b1, 6'd10},
    '{MODE_FREE,    7'd0,  6'd11, 1'b1, 1'b1, 6'd11},
    '{MODE_FREE,    7'd0,  6'd12, 1'b1, 1'b1, 6'd12},
    '{MODE_FREE,    7'd0,  6'd20, 1'b1, 1'b1, 6'd20},
    '{MODE_CONTIG,  7'd3,  6'd0,  1'b0, 1'b0, 6'd0},
    '{MODE_INDEXED, 7'd0,  6'd0,  1'b0, 1'b0, 6'd0}
  };

  block_bitmap_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void push_grant(input bit record, input logic ok,
                                     input logic [BLOCK_W-1:0] blk, input logic last);
    grant_t g;
    g.ok   = ok;
    g.blk  = blk;
    g.last = last;
    if (record) pending_grants = {pending_grants, g};
  endfunction

  function automatic void apply_request(input logic [MODE_W-1:0] mode,
                                        input logic [COUNT_W-1:0] count,
                                        input logic [BLOCK_W-1:0] blk, input bit record);
    int  need;
    int  run;
    int  start;
    int  got;
    int  i;
    bit  found;
    need  = count;
    run   = 0;
    start = 0;
    got   = 0;
    found = 1'b0;
    case (mode)
      MODE_CONTIG: begin
        if (need != 0 && need <= NUM_BLOCKS) begin
          for (i = 0; i < NUM_BLOCKS; i++) begin
            if (!found) begin
              if (free_blocks[i]) begin
                if (run == 0) start = i;
                run++;
                if (run >= need) found = 1'b1;
              end else begin
                run = 0;
              end
            end
          end
        end
        if (!found) begin
          push_grant(record, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < need; i++) begin
            free_blocks[start+i] = 1'b0;
            push_grant(record, 1'b1, BLOCK_W'(start + i), i + 1 == need);
          end
        end
      end
      MODE_INDEXED: begin
        need = need + 1;
        if ($countones(free_blocks) < need) begin
          push_grant(record, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < NUM_BLOCKS; i++) begin
            if (got < need && free_blocks[i]) begin
              free_blocks[i] = 1'b0;
              got++;
              push_grant(record, 1'b1, BLOCK_W'(i), got == need);
            end
          end
        end
      end
      MODE_FREE: begin
        free_blocks[blk] = 1'b1;
        push_grant(record, 1'b1, blk, 1'b1);
      end
      default: begin
        push_grant(record, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_block();
    int                 s;
    int                 i;
    bit                 found;
    logic [BLOCK_W-1:0] b;
    b     = BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1));
    s     = b;
    found = 1'b0;
    if ($urandom_range(0, 99) < 85) begin
      for (i = 0; i < NUM_BLOCKS; i++) begin
        if (!found && !free_blocks[(s + i) % NUM_BLOCKS]) begin
          b     = BLOCK_W'((s + i) % NUM_BLOCKS);
          found = 1'b1;
        end
      end
    end
    return b;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int c;
    c = $urandom_range(0, 99);
    if (c < 4) return '0;
    if (c < 80) return COUNT_W'($urandom_range(1, 6));
    if (c < 94) return COUNT_W'($urandom_range(7, NUM_BLOCKS));
    return COUNT_W'($urandom_range(NUM_BLOCKS + 1, 127));
  endfunction

  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [COUNT_W-1:0] count,
                              input logic [BLOCK_W-1:0] blk, input logic known,
                              input logic k_ok, input logic [BLOCK_W-1:0] k_blk);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, blk, count};
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(mode, count, blk, !known);
    if (known) push_grant(1'b1, k_ok, k_blk, 1'b1);
    if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
  endtask

  task automatic drain_grants();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int                 stall;
    grant_t             g;
    m_axis_tready = 1'b0;
    calm_rx       = 1'b0;
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 8);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected transaction ok=%0b block=%0d last=%0b", $time,
                 m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tlast);
        mismatches++;
      end else begin
        g = pending_grants.pop_front();
        if (m_axis_tdata[0] !== g.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, g.ok, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[6:1] !== g.blk) begin
          $display("%0t: block expected %0d actual %0d", $time, g.blk, m_axis_tdata[6:1]);
          mismatches++;
        end
        if (m_axis_tlast !== g.last) begin
          $display("%0t: last expected %0b actual %0b", $time, g.last, m_axis_tlast);
          mismatches++;
        end
      end
      if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
    end
  end

  initial begin
    int                    n;
    int                    i;
    int                    r;
    logic [NUM_BLOCKS-1:0] used;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_NONE;
    calm_tx       = 1'b0;
    free_blocks   = '1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].mode, dir_rows[k].count, dir_rows[k].blk,
                   dir_rows[k].known, dir_rows[k].k_ok, dir_rows[k].k_blk);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        used = ~free_blocks;
        for (i = 0; i < NUM_BLOCKS; i++) begin
          if (used[i]) begin
            send_request(MODE_FREE, COUNT_W'($urandom_range(0, 127)), BLOCK_W'(i),
                         1'b0, 1'b0, '0);
          end
        end
        drain_grants();
        send_request(MODE_CONTIG, COUNT_W'(NUM_BLOCKS), '0, 1'b0, 1'b0, '0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request(MODE_NONE, COUNT_W'($urandom_range(0, 127)),
                     BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'b0, 1'b0, '0);
      end else if (r < 45) begin
        send_request(MODE_FREE, COUNT_W'($urandom_range(0, 127)), pick_block(),
                     1'b0, 1'b0, '0);
      end else if (r < 72) begin
        send_request(MODE_CONTIG, pick_count(),
                     BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'b0, 1'b0, '0);
      end else begin
        send_request(MODE_INDEXED, pick_count(),
                     BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'b0, 1'b0, '0);
      end
    end

    drain_grants();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_datapath.sv
hw/rtl/bba_controller.sv
hw/rtl/block_bitmap_allocator.sv
tb/sv/testbench.sv
